[hdl/mpiq_pkg.sv]
// Shared types, constants and helpers for the measurement packet encoder.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package mpiq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;

    localparam int KIND_W     = 2;
    localparam int VAL_W      = 16;
    localparam int MEAS_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD    = 2'd0,
        KIND_UPDATE = 2'd1,
        KIND_ENCODE = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] CFG_CONTACT_SUPPORTED = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD       = 8'd1;
    localparam logic [BYTE_W-1:0]    MAX_PAYLOAD_RST       = 8'd20;

    localparam logic [MEAS_W-1:0] WIDE_LIMIT = 32'h0000_00ff;
    localparam logic [BYTE_W-1:0] FLAG_WIDE              = 8'h01 << 0;
    localparam logic [BYTE_W-1:0] FLAG_CONTACT_DETECTED  = 8'h01 << 1;
    localparam logic [BYTE_W-1:0] FLAG_CONTACT_SUPPORTED = 8'h01 << 2;
    localparam logic [BYTE_W-1:0] FLAG_INTERVALS         = 8'h01 << 4;

    // flags byte plus value bytes
    localparam logic [BYTE_W-1:0] LEN_NARROW = 8'd2;
    localparam logic [BYTE_W-1:0] LEN_WIDE   = 8'd5;
    localparam logic [1:0]        WIDE_LAST_BYTE = 2'd3;

    typedef struct packed {
        logic              contact_supported;
        logic [BYTE_W-1:0] max_payload_len;
    } t_cfg;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [VAL_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STATUS,
        S_FLAGS,
        S_VALUE,
        S_PAIR_LO,
        S_PAIR_HI
    } t_state;

    // slot index modulo QUEUE_DEPTH for sums below twice the depth
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        r = (s >= SUM_W'(QUEUE_DEPTH)) ? (s - SUM_W'(QUEUE_DEPTH)) : s;
        return r[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hdl/mpiq_if.sv]
// Channel interfaces: input items, result bytes and configuration writes.
// Depends on mpiq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mpiq_in_if;
    import mpiq_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  interval_value;
    logic              contact_flag;
    logic [MEAS_W-1:0] measurement;

    modport source (output valid, kind, interval_value, contact_flag, measurement,
                    input ready);
    modport sink   (input valid, kind, interval_value, contact_flag, measurement,
                    output ready);
endinterface

interface mpiq_out_if;
    import mpiq_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              is_packet;
    logic              queue_full;
    logic              last;

    modport source (output valid, out_byte, is_packet, queue_full, last, input ready);
    modport sink   (input valid, out_byte, is_packet, queue_full, last, output ready);
endinterface

interface mpiq_cfg_if;
    import mpiq_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/mpiq_store.sv]
// Interval store: one write port, one read port, registered read data.
// Depends on mpiq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpiq_store (
    input  wire                       i_clk,
    input  mpiq_pkg::t_mem_req        i_req,
    output logic [mpiq_pkg::VAL_W-1:0] o_rdata
);
    import mpiq_pkg::*;

    logic [VAL_W-1:0] r_mem [QUEUE_DEPTH];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hdl/mpiq_ctrl.sv]
// Sequencer: queue pointers, contact flag, packet byte walk and output register.
// Depends on mpiq_pkg, mpiq_if; drives the mpiq_store ports.
`timescale 1ns / 1ps
`default_nettype none

module mpiq_ctrl (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  mpiq_pkg::t_cfg              i_cfg,
    mpiq_in_if.sink                     i_in,
    mpiq_out_if.source                  o_out,
    output mpiq_pkg::t_mem_req          o_mem_req,
    input  wire [mpiq_pkg::VAL_W-1:0]   i_mem_rdata
);
    import mpiq_pkg::*;

    t_state            r_state,    n_state;
    logic [IDX_W-1:0]  r_head,     n_head;
    logic [CNT_W-1:0]  r_count,    n_count;
    logic              r_contact,  n_contact;
    logic [MEAS_W-1:0] r_meas,     n_meas;
    logic              r_wide,     n_wide;
    logic [BYTE_W-1:0] r_flags,    n_flags;
    logic [1:0]        r_byte_idx, n_byte_idx;
    logic [CNT_W-1:0]  r_pairs,    n_pairs;
    logic [IDX_W-1:0]  r_rd_ptr,   n_rd_ptr;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_pkt;
    logic              r_out_full;
    logic              r_out_last;

    logic              accept;
    logic              slot_free;
    logic              full;
    logic              in_wide;
    logic [BYTE_W-1:0] pkt_len;
    logic [BYTE_W-1:0] room;
    logic [CNT_W-1:0]  fits;
    logic              val_end;
    logic              emit;
    logic [BYTE_W-1:0] e_byte;
    logic              e_pkt;
    logic              e_last;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign slot_free  = !r_out_valid || o_out.ready;
    assign full       = (r_count == CNT_W'(QUEUE_DEPTH));

    // pairs that fit: (limit - len) / 2 when at least one pair fits
    assign in_wide = (i_in.measurement > WIDE_LIMIT);
    assign pkt_len = in_wide ? LEN_WIDE : LEN_NARROW;
    assign room    = (i_cfg.max_payload_len >= pkt_len + 8'd2)
                   ? ((i_cfg.max_payload_len - pkt_len) >> 1) : '0;
    assign fits    = (room >= BYTE_W'(r_count)) ? r_count : room[CNT_W-1:0];
    assign val_end = !r_wide || (r_byte_idx == WIDE_LAST_BYTE);

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_contact  = r_contact;
        n_meas     = r_meas;
        n_wide     = r_wide;
        n_flags    = r_flags;
        n_byte_idx = r_byte_idx;
        n_pairs    = r_pairs;
        n_rd_ptr   = r_rd_ptr;
        emit       = 1'b0;
        e_byte     = '0;
        e_pkt      = 1'b0;
        e_last     = 1'b0;
        o_mem_req.we    = 1'b0;
        // tail slot; equals head when full, which is the slot being dropped
        o_mem_req.waddr = wrap_idx(SUM_W'(r_head) + SUM_W'(r_count));
        o_mem_req.wdata = i_in.interval_value;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_kind'(i_in.kind))
                        KIND_ADD: begin
                            o_mem_req.we = 1'b1;
                            if (full) begin
                                n_head = wrap_idx(SUM_W'(r_head) + SUM_W'(1));
                            end else begin
                                n_count = r_count + CNT_W'(1);
                            end
                            n_state = S_STATUS;
                        end
                        KIND_UPDATE: begin
                            n_contact = i_in.contact_flag;
                            n_state   = S_STATUS;
                        end
                        KIND_ENCODE: begin
                            n_meas     = i_in.measurement;
                            n_wide     = in_wide;
                            n_flags    = (in_wide ? FLAG_WIDE : '0)
                                       | (r_contact ? FLAG_CONTACT_DETECTED : '0)
                                       | (i_cfg.contact_supported ? FLAG_CONTACT_SUPPORTED : '0)
                                       | ((r_count != '0) ? FLAG_INTERVALS : '0);
                            n_pairs    = fits;
                            n_rd_ptr   = r_head;
                            n_head     = wrap_idx(SUM_W'(r_head) + SUM_W'(fits));
                            n_count    = r_count - fits;
                            n_byte_idx = '0;
                            n_state    = S_FLAGS;
                        end
                        default: begin
                            n_state = S_STATUS;
                        end
                    endcase
                end
            end
            S_STATUS: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    e_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FLAGS: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    e_byte  = r_flags;
                    e_pkt   = 1'b1;
                    n_state = S_VALUE;
                end
            end
            S_VALUE: begin
                if (slot_free) begin
                    emit       = 1'b1;
                    e_byte     = r_meas[r_byte_idx*BYTE_W +: BYTE_W];
                    e_pkt      = 1'b1;
                    e_last     = val_end && (r_pairs == '0);
                    n_byte_idx = r_byte_idx + 2'd1;
                    if (val_end) begin
                        n_state = (r_pairs == '0) ? S_IDLE : S_PAIR_LO;
                    end
                end
            end
            S_PAIR_LO: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    e_byte  = i_mem_rdata[BYTE_W-1:0];
                    e_pkt   = 1'b1;
                    n_state = S_PAIR_HI;
                end
            end
            S_PAIR_HI: begin
                if (slot_free) begin
                    emit     = 1'b1;
                    e_byte   = i_mem_rdata[VAL_W-1:BYTE_W];
                    e_pkt    = 1'b1;
                    e_last   = (r_pairs == CNT_W'(1));
                    n_pairs  = r_pairs - CNT_W'(1);
                    n_rd_ptr = wrap_idx(SUM_W'(r_rd_ptr) + SUM_W'(1));
                    n_state  = (r_pairs == CNT_W'(1)) ? S_IDLE : S_PAIR_LO;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // read the next pointer so the data lines up with r_rd_ptr
        o_mem_req.raddr = n_rd_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_contact   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_contact <= n_contact;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_meas     <= n_meas;
        r_wide     <= n_wide;
        r_flags    <= n_flags;
        r_byte_idx <= n_byte_idx;
        r_pairs    <= n_pairs;
        r_rd_ptr   <= n_rd_ptr;
        if (emit) begin
            r_out_byte <= e_byte;
            r_out_pkt  <= e_pkt;
            r_out_full <= full;
            r_out_last <= e_last;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_byte   = r_out_byte;
    assign o_out.is_packet  = r_out_pkt;
    assign o_out.queue_full = r_out_full;
    assign o_out.last       = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_encode_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.kind == KIND_ENCODE)) |=> (r_state == S_FLAGS))
        else $error("encode did not start with flags byte");

    a_pairs_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PAIR_LO) || (r_state == S_PAIR_HI)) |-> (r_pairs != '0))
        else $error("pair state with no pairs left");

    a_status_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_pkt) |-> (r_out_last && (r_out_byte == '0)))
        else $error("malformed status result");

endmodule

`default_nettype wire

[hdl/measurement_packet_with_interval_queue.sv]
// Top level: configuration registers, sequencer and interval store.
// Depends on mpiq_pkg, mpiq_if, mpiq_store, mpiq_ctrl.
//
//  channel  | dir | transfer carries
//  ---------+-----+-----------------------------------------------------
//  i_in     | in  | kind, interval_value, contact_flag, measurement
//  o_out    | out | out_byte, is_packet, queue_full, last (one per byte)
//  i_cfg    | in  | index (0 contact_supported, 1 max_payload_len), data
//
// Add, update and unused kinds: accept, then status result.
// Encode: N = 2..37 bytes, one byte per cycle out of the output register while o_out
// is ready; interval bytes come from the store's registered read port.
// Reset (synchronous, i_rst_n low) empties the queue, clears the contact flag,
// sets contact_supported to 0 and max_payload_len to 20. No clearing pass.
// A stalled o_out holds the byte walk; i_in is taken only between items.
// i_cfg is always ready; writes to indexes beyond the list are dropped.
`timescale 1ns / 1ps
`default_nettype none

module measurement_packet_with_interval_queue (
    input  wire         i_clk,
    input  wire         i_rst_n,
    mpiq_in_if.sink     i_in,
    mpiq_out_if.source  o_out,
    mpiq_cfg_if.sink    i_cfg
);
    import mpiq_pkg::*;

    logic              r_contact_supported;
    logic [BYTE_W-1:0] r_max_payload_len;
    t_cfg              cfg;
    t_mem_req          mem_req;
    logic [VAL_W-1:0]  mem_rdata;

    // configuration registers; user writes only while the block is idle, unenforced
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_contact_supported <= 1'b0;
            r_max_payload_len   <= MAX_PAYLOAD_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_CONTACT_SUPPORTED: r_contact_supported <= i_cfg.data[0];
                CFG_MAX_PAYLOAD:       r_max_payload_len   <= i_cfg.data[BYTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.contact_supported = r_contact_supported;
    assign cfg.max_payload_len   = r_max_payload_len;

    // sequencer: owns queue head/count and walks the packet bytes
    mpiq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    // interval storage, registered read data
    mpiq_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

[tb/mpiq_result_checker.sv]
// Result checker for the measurement packet encoder: tracks input, config and
// result transfers, predicts every packet byte and status result, and counts failures.
// Depends on mpiq_pkg and the channel interfaces in mpiq_if.
`timescale 1ns / 1ps

module mpiq_result_checker (
    input  wire   i_clk,
    input  wire   i_rst_n,
    mpiq_in_if    i_in,
    mpiq_out_if   i_out,
    mpiq_cfg_if   i_cfg,
    output int    o_fail_count,
    output int    o_pending
);
    import mpiq_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_packet;
        logic              queue_full;
        logic              last;
    } t_result_byte;

    t_result_byte expected_bytes[$];

    // predictor state
    logic [VAL_W-1:0]  interval_mem [QUEUE_DEPTH];
    int unsigned       q_head;
    int unsigned       q_count;
    logic              contact_det;
    logic              contact_sup;
    logic [BYTE_W-1:0] payload_max;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_result_byte make_result(input logic [BYTE_W-1:0] b,
                                                 input logic pkt, input logic lst);
        t_result_byte r;
        r.out_byte   = b;
        r.is_packet  = pkt;
        r.queue_full = (q_count == QUEUE_DEPTH);
        r.last       = lst;
        return r;
    endfunction

    task automatic predict_packet_bytes(input t_kind k, input logic [VAL_W-1:0] ival,
                                        input logic cflag, input logic [MEAS_W-1:0] meas);
        logic [BYTE_W-1:0] pkt_bytes[$];
        logic [BYTE_W-1:0] flags;
        logic [VAL_W-1:0]  v;
        int unsigned       sent;
        if (k == KIND_ENCODE) begin
            flags = '0;
            if (contact_sup) flags |= FLAG_CONTACT_SUPPORTED;
            if (contact_det) flags |= FLAG_CONTACT_DETECTED;
            pkt_bytes.push_back('0);
            if (meas > WIDE_LIMIT) begin
                flags |= FLAG_WIDE;
                pkt_bytes.push_back(meas[7:0]);
                pkt_bytes.push_back(meas[15:8]);
                pkt_bytes.push_back(meas[23:16]);
                pkt_bytes.push_back(meas[31:24]);
            end else begin
                pkt_bytes.push_back(meas[7:0]);
            end
            // pending bit reflects queue state even when no pair fits
            if (q_count > 0) flags |= FLAG_INTERVALS;
            sent = 0;
            while (sent < q_count && pkt_bytes.size() + 2 <= payload_max) begin
                v = interval_mem[(q_head + sent) % QUEUE_DEPTH];
                pkt_bytes.push_back(v[7:0]);
                pkt_bytes.push_back(v[15:8]);
                sent++;
            end
            pkt_bytes[0] = flags;
            q_head  = (q_head + sent) % QUEUE_DEPTH;
            q_count = q_count - sent;
            foreach (pkt_bytes[i])
                expected_bytes.push_back(make_result(pkt_bytes[i], 1'b1,
                                                     i == pkt_bytes.size() - 1));
        end else begin
            if (k == KIND_ADD) begin
                // full queue: oldest interval is dropped
                if (q_count >= QUEUE_DEPTH) begin
                    q_head  = (q_head + 1) % QUEUE_DEPTH;
                    q_count = QUEUE_DEPTH - 1;
                end
                interval_mem[(q_head + q_count) % QUEUE_DEPTH] = ival;
                q_count++;
            end else if (k == KIND_UPDATE) begin
                contact_det = cflag;
            end
            expected_bytes.push_back(make_result('0, 1'b0, 1'b1));
        end
    endtask

    always @(posedge i_clk) begin
        t_result_byte got;
        t_result_byte want;
        if (!i_rst_n) begin
            q_head      = 0;
            q_count     = 0;
            contact_det = 1'b0;
            contact_sup = 1'b0;
            payload_max = MAX_PAYLOAD_RST;
            expected_bytes.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_CONTACT_SUPPORTED: contact_sup = i_cfg.data[0];
                    CFG_MAX_PAYLOAD:       payload_max = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                predict_packet_bytes(t_kind'(i_in.kind), i_in.interval_value,
                                     i_in.contact_flag, i_in.measurement);
            if (i_out.valid && i_out.ready) begin
                got.out_byte   = i_out.out_byte;
                got.is_packet  = i_out.is_packet;
                got.queue_full = i_out.queue_full;
                got.last       = i_out.last;
                if (expected_bytes.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%t unexpected result: byte %02h pkt %b full %b last %b",
                                 $realtime, got.out_byte, got.is_packet, got.queue_full,
                                 got.last);
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.out_byte !== want.out_byte || got.is_packet !== want.is_packet ||
                        got.queue_full !== want.queue_full || got.last !== want.last) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"%t mismatch: expected byte %02h pkt %b full %b last %b,",
                                      " got byte %02h pkt %b full %b last %b"},
                                     $realtime, want.out_byte, want.is_packet,
                                     want.queue_full, want.last, got.out_byte,
                                     got.is_packet, got.queue_full, got.last);
                    end
                end
            end
        end
        o_pending = expected_bytes.size();
    end

endmodule

[tb/tb_measurement_packet_with_interval_queue.sv]
// Testbench top for the measurement packet encoder: drives item, config and
// result channels, with random idling on the item and result sides, and reports the verdict.
// Depends on mpiq_pkg, mpiq_if, the block and mpiq_result_checker.
`timescale 1ns / 1ps

module tb_measurement_packet_with_interval_queue;
    import mpiq_pkg::*;

    // index outside the register list; the block drops such writes
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'd2;

    logic i_clk;
    logic i_rst_n;
    logic steady = 1'b0;    // when set, neither side idles
    int   fail_count;
    int   pending;

    mpiq_in_if  in_ch ();
    mpiq_out_if out_ch ();
    mpiq_cfg_if cfg_ch ();

    measurement_packet_with_interval_queue i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    mpiq_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop: prints FAIL and ends the run if it has not finished by then.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Result side backpressure: ready drops at random, with a chance of one in ten,
    // except during the steady phase.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready = steady || ($urandom_range(99) >= 10);
        end
    end

    // All tasks start and end at a falling edge. valid is left high after a
    // transfer so back-to-back items keep it asserted; only gaps lower it.
    task automatic send_item(input t_kind k, input logic [VAL_W-1:0] ival,
                             input logic cflag, input logic [MEAS_W-1:0] meas);
        while (!steady && $urandom_range(99) < 10) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid          = 1'b1;
        in_ch.kind           = k;
        in_ch.interval_value = ival;
        in_ch.contact_flag   = cflag;
        in_ch.measurement    = meas;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Drain: every item yields at least one result, so once nothing is
    // outstanding the block is idle; extra falling edges follow as margin.
    task automatic settle();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Half the values fit one byte, the rest are full 32-bit random.
    function automatic logic [MEAS_W-1:0] pick_measurement();
        return ($urandom_range(1) == 0) ? MEAS_W'($urandom_range(255)) : $urandom;
    endfunction

    initial begin
        int               r;
        int               add_pct;
        t_kind            k;
        logic [VAL_W-1:0] v;
        logic [7:0]       limit;

        // every block input known from time zero
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.kind           = KIND_NONE;
        in_ch.interval_value = '0;
        in_ch.contact_flag   = 1'b0;
        in_ch.measurement    = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_CONTACT_SUPPORTED;
        cfg_ch.data          = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // ---- directed part, reset config (not supported, limit 20) ----
        // empty queue: narrow value at both ends of the one-byte range
        send_item(KIND_ENCODE, 16'h0000, 1'b0, 32'h0000_0000);
        send_item(KIND_ENCODE, 16'hffff, 1'b1, 32'h0000_00ff);
        // contact detected, then the smallest wide value
        send_item(KIND_UPDATE, 16'h0000, 1'b1, 32'h0000_0000);
        send_item(KIND_ENCODE, 16'h0000, 1'b0, 32'h0000_0100);
        send_item(KIND_UPDATE, 16'hffff, 1'b0, 32'hffff_ffff);
        // unused kind: status only, nothing changes
        send_item(KIND_NONE, VAL_W'($urandom), 1'($urandom_range(1)), $urandom);

        // 17 adds: fills the queue and then drops the oldest entry
        for (int i = 0; i < 17; i++) begin
            v = (i == 0) ? 16'h0000 : (i == 1) ? 16'hffff : VAL_W'($urandom);
            send_item(KIND_ADD, v, 1'($urandom_range(1)), $urandom);
        end
        // widest value; limit 20 lets only part of the queue out
        send_item(KIND_ENCODE, 16'h0000, 1'b0, 32'hffff_ffff);

        // limit below header size: flags and value still go out, no pairs,
        // pending bit still set
        settle();
        write_reg(CFG_CONTACT_SUPPORTED, 8'd1);
        write_reg(CFG_MAX_PAYLOAD, 8'd1);
        write_reg(CFG_UNMAPPED, 8'h5a);
        send_item(KIND_ENCODE, 16'h0000, 1'b0, 32'h0000_0012);

        // limit above the nominal range drains everything left
        settle();
        write_reg(CFG_MAX_PAYLOAD, 8'd255);
        send_item(KIND_ENCODE, 16'h0000, 1'b0, pick_measurement());

        // ---- random part: eight phases with different limits and mixes ----
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin limit = 8'd244; add_pct = 45; end
                1: begin limit = 8'd1;   add_pct = 70; end
                2: begin limit = 8'd20;  add_pct = 50; end
                3: begin limit = 8'd255; add_pct = 60; end
                4: begin limit = 8'd3;   add_pct = 40; end
                5: begin limit = 8'd37;  add_pct = 55; end
                6: begin limit = 8'd2;   add_pct = 65; end
                default: begin limit = 8'd7; add_pct = 50; end
            endcase
            settle();
            write_reg(CFG_CONTACT_SUPPORTED, CFG_DATA_W'($urandom_range(1)));
            write_reg(CFG_MAX_PAYLOAD, limit);
            // one phase with no idling on either side
            steady = (p == 2);
            repeat (11) begin
                r = $urandom_range(99);
                if (r < add_pct)
                    k = KIND_ADD;
                else if (r < add_pct + 25)
                    k = KIND_ENCODE;
                else if (r < add_pct + 37)
                    k = KIND_UPDATE;
                else
                    k = KIND_NONE;
                send_item(k, VAL_W'($urandom), 1'($urandom_range(1)), pick_measurement());
            end
        end
        steady = 1'b0;

        // wait out the tail: longest packet is 37 bytes
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
